// File: sv/assert_macros.svh
// Concurrent assertion helpers, sampled on clk and quiet during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset
`define DSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent implies consequent on the next edge
`define DSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/dsc_pkg.sv
package dsc_pkg;

    localparam int AMOUNT_W = 16;
    localparam int AVAIL_W  = 21;
    localparam int CMP_W    = AVAIL_W + 1;
    localparam int ID_W     = 4;
    localparam int PROC_W   = 4;
    localparam int RES_W    = 3;
    localparam int KIND_W   = 2;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;
    localparam int PCNT_W   = 5;
    localparam int RCNT_W   = 4;

    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MAX   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_AVAIL = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RUN   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_COUNT  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESOURCE_COUNT = 4'd1;

    typedef struct packed {
        logic we_alloc;
        logic we_max;
    } tbl_ctl_t;

endpackage

// File: sv/dsc_cfg_if.sv
interface dsc_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [dsc_pkg::CFG_IDX_W-1:0]     index;
    logic [dsc_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/dsc_in_if.sv
interface dsc_in_if;
    logic                           valid;
    logic                           ready;
    logic [dsc_pkg::KIND_W-1:0]     kind;
    logic [dsc_pkg::PROC_W-1:0]     process;
    logic [dsc_pkg::RES_W-1:0]      resource;
    logic [dsc_pkg::AMOUNT_W-1:0]   amount;

    modport source (output valid, output kind, output process, output resource,
                    output amount, input ready);
    modport sink   (input valid, input kind, input process, input resource,
                    input amount, output ready);
endinterface

// File: sv/dsc_out_if.sv
interface dsc_out_if;
    logic                         valid;
    logic                         ready;
    logic [dsc_pkg::ID_W-1:0]     process_id;
    logic                         safe;
    logic                         last;

    modport source (output valid, output process_id, output safe, output last,
                    input ready);
    modport sink   (input valid, input process_id, input safe, input last,
                     output ready);
endinterface

// File: sv/dsc_tables.sv
module dsc_tables #(
    parameter int AW = 7
) (
    input  logic                            clk,
    input  dsc_pkg::tbl_ctl_t               ctl,
    input  logic [AW-1:0]                   waddr,
    input  logic [dsc_pkg::AMOUNT_W-1:0]    wdata,
    input  logic [AW-1:0]                   raddr,
    output logic [dsc_pkg::AMOUNT_W-1:0]    alloc_q,
    output logic [dsc_pkg::AMOUNT_W-1:0]    max_q
);

    logic [dsc_pkg::AMOUNT_W-1:0] alloc_mem [2**AW];
    logic [dsc_pkg::AMOUNT_W-1:0] max_mem   [2**AW];

    always_ff @(posedge clk)
    begin
        if (ctl.we_alloc)
        begin
            alloc_mem[waddr] <= wdata;
        end
        alloc_q <= alloc_mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.we_max)
        begin
            max_mem[waddr] <= wdata;
        end
        max_q <= max_mem[raddr];
    end

endmodule

// File: sv/dsc_seq_mem.sv
module dsc_seq_mem #(
    parameter int PW = 4
) (
    input  logic          clk,
    input  logic          we,
    input  logic [PW-1:0] waddr,
    input  logic [PW-1:0] wdata,
    input  logic [PW-1:0] raddr,
    output logic [PW-1:0] rdata
);

    logic [PW-1:0] seq_mem [2**PW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            seq_mem[waddr] <= wdata;
        end
        rdata <= seq_mem[raddr];
    end

endmodule

// File: sv/deadlock_safety_check_core.sv
// Load beats: one per cycle while idle, no result.
// Run beat: input held off until the run ends; each pass scans every process, tests each
// resource of an unfinished one and, if all fit, releases its allocations; process_count passes.
// Then a decision, and one safe result per process in finish order, or one unsafe result.
// Tables are read through the single read port; output stalls hold the emit states.
// Reset: control, counts (process_count 16, resource_count 8), finished flags; tables undefined.
`include "assert_macros.svh"

module deadlock_safety_check_core #(
    parameter int MAX_PROCESSES = 16,
    parameter int MAX_RESOURCES = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    dsc_cfg_if.sink         cfg,
    dsc_in_if.sink          item,
    dsc_out_if.source       result
);

    localparam int PW  = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int RW  = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
    localparam int NPW = $clog2(MAX_PROCESSES + 1);
    localparam int NRW = $clog2(MAX_RESOURCES + 1);
    localparam int AW  = PW + RW;
    localparam int AVW = dsc_pkg::AVAIL_W;
    localparam int CW  = dsc_pkg::CMP_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SCAN = 4'd1;
    localparam logic [3:0] S_RD   = 4'd2;
    localparam logic [3:0] S_CHK  = 4'd3;
    localparam logic [3:0] S_ARD  = 4'd4;
    localparam logic [3:0] S_ADD  = 4'd5;
    localparam logic [3:0] S_EMIT = 4'd6;
    localparam logic [3:0] S_ORD  = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    logic [3:0]                     state_reg, state_next;
    logic [dsc_pkg::PCNT_W-1:0]     pcount_reg;
    logic [dsc_pkg::RCNT_W-1:0]     rcount_reg;
    logic [NPW-1:0]                 nproc_reg, nproc_next;
    logic [NRW-1:0]                 nres_reg, nres_next;
    logic [PW-1:0]                  p_reg, p_next;
    logic [PW-1:0]                  pass_reg, pass_next;
    logic [RW-1:0]                  r_reg, r_next;
    logic [NPW-1:0]                 seq_count_reg, seq_count_next;
    logic [NPW-1:0]                 o_idx_reg, o_idx_next;
    logic [MAX_PROCESSES-1:0]       finished_reg, finished_next;
    logic [AVW-1:0]                 avail_reg [MAX_RESOURCES];
    logic [AVW-1:0]                 work_reg  [MAX_RESOURCES];

    logic                           out_valid_reg;
    logic [dsc_pkg::ID_W-1:0]       out_id_reg;
    logic                           out_safe_reg;
    logic                           out_last_reg;

    dsc_pkg::tbl_ctl_t              tbl_ctl;
    logic [AW-1:0]                  tbl_waddr;
    logic [AW-1:0]                  tbl_raddr;
    logic [dsc_pkg::AMOUNT_W-1:0]   alloc_q, max_q;
    logic [PW-1:0]                  seq_q;
    logic                           seq_we;

    logic                           in_beat, out_free, load_out;
    logic [dsc_pkg::ID_W-1:0]       load_id;
    logic                           load_safe, load_last;
    logic                           idx_ok, p_last, pass_last, r_last, o_last;
    logic                           fits;
    logic signed [CW-1:0]           need;
    logic [CW-1:0]                  sum;
    logic [AVW-1:0]                 sat_sum;

    assign in_beat   = item.valid && item.ready;
    assign item.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign out_free  = !out_valid_reg || result.ready;

    assign idx_ok    = (int'(item.resource) < MAX_RESOURCES)
                    && ((item.kind == dsc_pkg::KIND_AVAIL)
                        || (int'(item.process) < MAX_PROCESSES));
    assign tbl_ctl.we_alloc = in_beat && idx_ok && (item.kind == dsc_pkg::KIND_ALLOC);
    assign tbl_ctl.we_max   = in_beat && idx_ok && (item.kind == dsc_pkg::KIND_MAX);
    assign tbl_waddr = {PW'(item.process), RW'(item.resource)};
    assign tbl_raddr = {p_reg, r_reg};

    assign p_last    = (NPW'(p_reg) + NPW'(1)) == nproc_reg;
    assign pass_last = (NPW'(pass_reg) + NPW'(1)) == nproc_reg;
    assign r_last    = (NRW'(r_reg) + NRW'(1)) == nres_reg;
    assign o_last    = (o_idx_reg + NPW'(1)) == nproc_reg;

    assign need = $signed({{(CW-dsc_pkg::AMOUNT_W){1'b0}}, max_q})
                - $signed({{(CW-dsc_pkg::AMOUNT_W){1'b0}}, alloc_q});
    assign fits = need <= $signed({1'b0, work_reg[r_reg]});
    assign sum  = {1'b0, work_reg[r_reg]} + CW'(alloc_q);
    assign sat_sum = sum[CW-1] ? {AVW{1'b1}} : sum[AVW-1:0];

    assign seq_we = (state_reg == S_ADD) && r_last;

    dsc_tables #(.AW(AW)) u_tables (
        .clk     (clk),
        .ctl     (tbl_ctl),
        .waddr   (tbl_waddr),
        .wdata   (item.amount),
        .raddr   (tbl_raddr),
        .alloc_q (alloc_q),
        .max_q   (max_q)
    );

    dsc_seq_mem #(.PW(PW)) u_seq (
        .clk   (clk),
        .we    (seq_we),
        .waddr (seq_count_reg[PW-1:0]),
        .wdata (p_reg),
        .raddr (o_idx_reg[PW-1:0]),
        .rdata (seq_q)
    );

    always_comb
    begin
        nproc_next = nproc_reg;
        nres_next  = nres_reg;
        if (pcount_reg == '0)
        begin
            nproc_next = NPW'(1);
        end
        else if (int'(pcount_reg) > MAX_PROCESSES)
        begin
            nproc_next = NPW'(MAX_PROCESSES);
        end
        else
        begin
            nproc_next = NPW'(pcount_reg);
        end
        if (rcount_reg == '0)
        begin
            nres_next = NRW'(1);
        end
        else if (int'(rcount_reg) > MAX_RESOURCES)
        begin
            nres_next = NRW'(MAX_RESOURCES);
        end
        else
        begin
            nres_next = NRW'(rcount_reg);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        p_next         = p_reg;
        pass_next      = pass_reg;
        r_next         = r_reg;
        seq_count_next = seq_count_reg;
        o_idx_next     = o_idx_reg;
        finished_next  = finished_reg;
        load_out       = 1'b0;
        load_id        = '0;
        load_safe      = 1'b0;
        load_last      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_beat && (item.kind == dsc_pkg::KIND_RUN))
                begin
                    p_next         = '0;
                    pass_next      = '0;
                    r_next         = '0;
                    seq_count_next = '0;
                    finished_next  = '0;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                r_next = '0;
                if (finished_reg[p_reg])
                begin
                    state_next = S_EMIT;
                    if (!p_last)
                    begin
                        p_next     = p_reg + PW'(1);
                        state_next = S_SCAN;
                    end
                    else if (!pass_last)
                    begin
                        p_next     = '0;
                        pass_next  = pass_reg + PW'(1);
                        state_next = S_SCAN;
                    end
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (!fits)
                begin
                    r_next     = '0;
                    state_next = S_EMIT;
                    if (!p_last)
                    begin
                        p_next     = p_reg + PW'(1);
                        state_next = S_SCAN;
                    end
                    else if (!pass_last)
                    begin
                        p_next     = '0;
                        pass_next  = pass_reg + PW'(1);
                        state_next = S_SCAN;
                    end
                end
                else if (r_last)
                begin
                    r_next     = '0;
                    state_next = S_ARD;
                end
                else
                begin
                    r_next     = r_reg + RW'(1);
                    state_next = S_RD;
                end
            end
            S_ARD:
            begin
                state_next = S_ADD;
            end
            S_ADD:
            begin
                if (r_last)
                begin
                    r_next                = '0;
                    finished_next[p_reg]  = 1'b1;
                    seq_count_next        = seq_count_reg + NPW'(1);
                    state_next            = S_EMIT;
                    if (!p_last)
                    begin
                        p_next     = p_reg + PW'(1);
                        state_next = S_SCAN;
                    end
                    else if (!pass_last)
                    begin
                        p_next     = '0;
                        pass_next  = pass_reg + PW'(1);
                        state_next = S_SCAN;
                    end
                end
                else
                begin
                    r_next     = r_reg + RW'(1);
                    state_next = S_ARD;
                end
            end
            S_EMIT:
            begin
                o_idx_next = '0;
                if (seq_count_reg != nproc_reg)
                begin
                    if (out_free)
                    begin
                        load_out   = 1'b1;
                        load_last  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_ORD;
                end
            end
            S_ORD:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    load_out  = 1'b1;
                    load_id   = dsc_pkg::ID_W'(seq_q);
                    load_safe = 1'b1;
                    load_last = o_last;
                    if (o_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        o_idx_next = o_idx_reg + NPW'(1);
                        state_next = S_ORD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pcount_reg    <= dsc_pkg::PCNT_W'(16);
            rcount_reg    <= dsc_pkg::RCNT_W'(8);
            nproc_reg     <= NPW'(1);
            nres_reg      <= NRW'(1);
            p_reg         <= '0;
            pass_reg      <= '0;
            r_reg         <= '0;
            seq_count_reg <= '0;
            o_idx_reg     <= '0;
            finished_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            p_reg         <= p_next;
            pass_reg      <= pass_next;
            r_reg         <= r_next;
            seq_count_reg <= seq_count_next;
            o_idx_reg     <= o_idx_next;
            finished_reg  <= finished_next;
            if (in_beat && (item.kind == dsc_pkg::KIND_RUN))
            begin
                nproc_reg <= nproc_next;
                nres_reg  <= nres_next;
            end
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == dsc_pkg::REG_PROCESS_COUNT)
                begin
                    pcount_reg <= cfg.data[dsc_pkg::PCNT_W-1:0];
                end
                else if (cfg.index == dsc_pkg::REG_RESOURCE_COUNT)
                begin
                    rcount_reg <= cfg.data[dsc_pkg::RCNT_W-1:0];
                end
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_id_reg   <= load_id;
            out_safe_reg <= load_safe;
            out_last_reg <= load_last;
        end
        if (in_beat && (item.kind == dsc_pkg::KIND_AVAIL) && idx_ok)
        begin
            avail_reg[RW'(item.resource)] <= AVW'(item.amount);
        end
        if (in_beat && (item.kind == dsc_pkg::KIND_RUN))
        begin
            work_reg <= avail_reg;
        end
        else if (state_reg == S_ADD)
        begin
            work_reg[r_reg] <= sat_sum;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.process_id = out_id_reg;
    assign result.safe       = out_safe_reg;
    assign result.last       = out_last_reg;

    `DSC_ASSERT(a_seq_bound, (state_reg == S_IDLE) || (seq_count_reg <= nproc_reg),
        "sequence count exceeds process count")
    `DSC_ASSERT(a_flags_match, $countones(finished_reg) == int'(seq_count_reg),
        "finished flags disagree with sequence count")
    `DSC_ASSERT_NEXT(a_last_ends_run, load_out && load_last,
        (state_reg == S_IDLE) && out_valid_reg && result.last,
        "final result did not end the run")

endmodule

// File: sim/deadlock_safety_check_core_tb.sv
`timescale 1ns / 100ps

module deadlock_safety_check_core_tb;

    typedef struct {
        logic [dsc_pkg::ID_W-1:0] id;
        logic                     safe;
        logic                     last;
    } outcome_t;

    typedef struct {
        logic [dsc_pkg::KIND_W-1:0]   kind;
        logic [dsc_pkg::PROC_W-1:0]   process;
        logic [dsc_pkg::RES_W-1:0]    resource;
        logic [dsc_pkg::AMOUNT_W-1:0] amount;
        bit                           typed;
        outcome_t                     want;
    } beat_t;

    localparam int NPROC = 16;
    localparam int NRES  = 8;
    localparam logic [dsc_pkg::AVAIL_W-1:0] WORK_CEIL = {dsc_pkg::AVAIL_W{1'b1}};

    logic clk;
    logic rst_n;

    dsc_cfg_if cfg_bus();
    dsc_in_if  item_bus();
    dsc_out_if res_bus();

    deadlock_safety_check_core uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus.sink),
        .item   (item_bus.sink),
        .result (res_bus.source)
    );

    logic [dsc_pkg::AMOUNT_W-1:0] alloc_tbl [NPROC][NRES];
    logic [dsc_pkg::AMOUNT_W-1:0] claim_tbl [NPROC][NRES];
    logic [dsc_pkg::AVAIL_W-1:0]  avail_vec [NRES];
    logic [dsc_pkg::PCNT_W-1:0]   proc_cnt_reg;
    logic [dsc_pkg::RCNT_W-1:0]   res_cnt_reg;

    outcome_t pending_outcomes[$];
    int errors;
    int beats_sent;
    int checks_run;
    int safe_seen;
    int unsafe_seen;
    int results_seen;
    bit no_idle;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #30ms;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic predict_safety(output outcome_t seq[$]);
        int nproc;
        int nres;
        int need;
        bit fits;
        bit done [NPROC];
        logic [dsc_pkg::AVAIL_W:0] sum;
        logic [dsc_pkg::AVAIL_W-1:0] work [NRES];
        logic [dsc_pkg::ID_W-1:0] order[$];
        nproc = (proc_cnt_reg == 0) ? 1 : ((proc_cnt_reg > NPROC) ? NPROC : proc_cnt_reg);
        nres  = (res_cnt_reg == 0) ? 1 : ((res_cnt_reg > NRES) ? NRES : res_cnt_reg);
        seq.delete();
        for (int r = 0; r < NRES; r++)
            work[r] = avail_vec[r];
        for (int p = 0; p < NPROC; p++)
            done[p] = 1'b0;
        for (int pass = 0; pass < nproc; pass++)
        begin
            for (int p = 0; p < nproc; p++)
            begin
                if (!done[p])
                begin
                    fits = 1'b1;
                    for (int r = 0; r < nres; r++)
                    begin
                        need = int'({16'd0, claim_tbl[p][r]}) - int'({16'd0, alloc_tbl[p][r]});
                        if (need > int'({11'd0, work[r]}))
                            fits = 1'b0;
                    end
                    if (fits)
                    begin
                        order.push_back(p[dsc_pkg::ID_W-1:0]);
                        for (int r = 0; r < nres; r++)
                        begin
                            sum = work[r] + alloc_tbl[p][r];
                            work[r] = (sum > WORK_CEIL) ? WORK_CEIL
                                                        : sum[dsc_pkg::AVAIL_W-1:0];
                        end
                        done[p] = 1'b1;
                    end
                end
            end
        end
        if (order.size() < nproc)
            seq.push_back('{id: '0, safe: 1'b0, last: 1'b1});
        else
            for (int i = 0; i < nproc; i++)
                seq.push_back('{id: order[i], safe: 1'b1, last: (i == nproc - 1)});
    endtask

    task automatic send_beat(input beat_t b);
        outcome_t seq[$];
        @(negedge clk);
        while (!no_idle && $urandom_range(0, 99) < 14)
        begin
            item_bus.valid <= 1'b0;
            @(negedge clk);
        end
        item_bus.valid    <= 1'b1;
        item_bus.kind     <= b.kind;
        item_bus.process  <= b.process;
        item_bus.resource <= b.resource;
        item_bus.amount   <= b.amount;
        do
            @(posedge clk);
        while (!item_bus.ready);
        beats_sent++;
        case (b.kind)
            dsc_pkg::KIND_ALLOC: alloc_tbl[b.process][b.resource] = b.amount;
            dsc_pkg::KIND_MAX:   claim_tbl[b.process][b.resource] = b.amount;
            dsc_pkg::KIND_AVAIL: avail_vec[b.resource] = {5'd0, b.amount};
            default:
            begin
                checks_run++;
                predict_safety(seq);
                if (b.typed)
                    pending_outcomes.push_back(b.want);
                else
                    foreach (seq[i])
                        pending_outcomes.push_back(seq[i]);
            end
        endcase
    endtask

    task automatic release_item();
        @(negedge clk);
        item_bus.valid <= 1'b0;
    endtask

    task automatic write_reg(input logic [dsc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dsc_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        if (idx == dsc_pkg::REG_PROCESS_COUNT)
            proc_cnt_reg = val[dsc_pkg::PCNT_W-1:0];
        else
            res_cnt_reg = val[dsc_pkg::RCNT_W-1:0];
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic beat_t load_beat(input logic [dsc_pkg::KIND_W-1:0] k, input int p,
                                        input int r, input int a);
        beat_t b;
        b.kind     = k;
        b.process  = p[dsc_pkg::PROC_W-1:0];
        b.resource = r[dsc_pkg::RES_W-1:0];
        b.amount   = a[dsc_pkg::AMOUNT_W-1:0];
        b.typed    = 1'b0;
        b.want     = '{id: '0, safe: 1'b0, last: 1'b0};
        return b;
    endfunction

    function automatic beat_t random_beat();
        int pick;
        int amt;
        logic [dsc_pkg::KIND_W-1:0] k;
        pick = $urandom_range(0, 99);
        if (pick < 12)
            k = dsc_pkg::KIND_RUN;
        else if (pick < 45)
            k = dsc_pkg::KIND_ALLOC;
        else if (pick < 80)
            k = dsc_pkg::KIND_MAX;
        else
            k = dsc_pkg::KIND_AVAIL;
        pick = $urandom_range(0, 99);
        if (pick < 75)
            amt = $urandom_range(0, 12);
        else if (pick < 85)
            amt = 0;
        else if (pick < 93)
            amt = $urandom_range(0, 40);
        else
            amt = $urandom_range(0, 65535);
        return load_beat(k, $urandom_range(0, 15), $urandom_range(0, 7), amt);
    endfunction

    // receiver: random stalls plus one long hold-off
    initial
    begin
        bit held;
        held = 1'b0;
        res_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && results_seen >= 20)
            begin
                held = 1'b1;
                res_bus.ready <= 1'b0;
                for (int c = 0; c < 2500; c++)
                    @(negedge clk);
            end
            res_bus.ready <= no_idle || ($urandom_range(0, 99) >= 14);
        end
    end

    always @(posedge clk)
    begin
        outcome_t exp_o;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            results_seen++;
            if (res_bus.safe)
                safe_seen++;
            else
                unsafe_seen++;
            if (pending_outcomes.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected beat: id=%0d safe=%0b last=%0b",
                             res_bus.process_id, res_bus.safe, res_bus.last);
            end
            else
            begin
                exp_o = pending_outcomes.pop_front();
                if (res_bus.process_id !== exp_o.id || res_bus.safe !== exp_o.safe ||
                    res_bus.last !== exp_o.last)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp id=%0d safe=%0b last=%0b, got id=%0d safe=%0b last=%0b",
                                 exp_o.id, exp_o.safe, exp_o.last,
                                 res_bus.process_id, res_bus.safe, res_bus.last);
                end
            end
        end
    end

    initial
    begin
        beat_t directed_rows[$];
        beat_t b;
        logic [dsc_pkg::CFG_DATA_W-1:0] phase_pc [6];
        logic [dsc_pkg::CFG_DATA_W-1:0] phase_rc [6];
        errors = 0;
        beats_sent = 0;
        checks_run = 0;
        safe_seen = 0;
        unsafe_seen = 0;
        results_seen = 0;
        no_idle = 1'b0;
        proc_cnt_reg = 5'd16;
        res_cnt_reg = 4'd8;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = '0;
        cfg_bus.data = '0;
        item_bus.valid = 1'b0;
        item_bus.kind = dsc_pkg::KIND_ALLOC;
        item_bus.process = '0;
        item_bus.resource = '0;
        item_bus.amount = '0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // fill every table entry before the first check
        for (int p = 0; p < NPROC; p++)
            for (int r = 0; r < NRES; r++)
            begin
                send_beat(load_beat(dsc_pkg::KIND_ALLOC, p, r, $urandom_range(0, 6)));
                send_beat(load_beat(dsc_pkg::KIND_MAX, p, r, $urandom_range(0, 12)));
            end
        for (int r = 0; r < NRES; r++)
            send_beat(load_beat(dsc_pkg::KIND_AVAIL, 0, r, $urandom_range(4, 20)));

        directed_rows.push_back(load_beat(dsc_pkg::KIND_RUN, 0, 0, 0));
        directed_rows.push_back(load_beat(dsc_pkg::KIND_AVAIL, 15, 0, 0));
        directed_rows.push_back(load_beat(dsc_pkg::KIND_MAX, 5, 0, 65535));
        b = load_beat(dsc_pkg::KIND_RUN, 15, 7, 65535);
        b.typed = 1'b1;
        b.want = '{id: '0, safe: 1'b0, last: 1'b1};
        directed_rows.push_back(b);
        directed_rows.push_back(load_beat(dsc_pkg::KIND_ALLOC, 5, 0, 65535));
        directed_rows.push_back(load_beat(dsc_pkg::KIND_RUN, 0, 0, 0));
        directed_rows.push_back(load_beat(dsc_pkg::KIND_MAX, 15, 7, 0));
        directed_rows.push_back(load_beat(dsc_pkg::KIND_ALLOC, 15, 7, 65535));
        directed_rows.push_back(load_beat(dsc_pkg::KIND_AVAIL, 0, 7, 65535));
        directed_rows.push_back(load_beat(dsc_pkg::KIND_RUN, 0, 0, 0));
        directed_rows.push_back(load_beat(dsc_pkg::KIND_AVAIL, 0, 2, 0));
        directed_rows.push_back(load_beat(dsc_pkg::KIND_MAX, 0, 2, 30));
        directed_rows.push_back(load_beat(dsc_pkg::KIND_ALLOC, 0, 2, 0));
        directed_rows.push_back(load_beat(dsc_pkg::KIND_ALLOC, 1, 2, 30));
        directed_rows.push_back(load_beat(dsc_pkg::KIND_MAX, 1, 2, 30));
        directed_rows.push_back(load_beat(dsc_pkg::KIND_RUN, 0, 0, 0));
        directed_rows.push_back(load_beat(dsc_pkg::KIND_ALLOC, 0, 2, 65535));
        directed_rows.push_back(load_beat(dsc_pkg::KIND_MAX, 0, 2, 65535));
        directed_rows.push_back(load_beat(dsc_pkg::KIND_RUN, 10, 5, 21845));
        foreach (directed_rows[i])
            send_beat(directed_rows[i]);
        release_item();

        phase_pc = '{8'd1, 8'd16, 8'd0, 8'd31, 8'd5, 8'hE3};
        phase_rc = '{8'd1, 8'd8, 8'd0, 8'd15, 8'd3, 8'hF2};
        for (int ph = 0; ph < 6; ph++)
        begin
            wait_drained();
            write_reg(dsc_pkg::REG_PROCESS_COUNT, phase_pc[ph]);
            write_reg(dsc_pkg::REG_RESOURCE_COUNT, phase_rc[ph]);
            no_idle = (ph == 3);
            for (int i = 0; i < 10; i++)
                send_beat(random_beat());
            send_beat(load_beat(dsc_pkg::KIND_RUN, 0, 0, 0));
            release_item();
        end
        no_idle = 1'b0;

        wait_drained();
        $display("%0d beats sent, %0d safety checks, %0d safe and %0d unsafe results",
                 beats_sent, checks_run, safe_seen, unsafe_seen);
        $display("counts swept from one to their limits, including zero and oversized writes");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
